[hw/rtl/esae_pkg.sv]
// esae_pkg: shared types and constants of the ethernet source address extractor
// used by esae_parser and ethernet_source_address_extractor_unit; no dependencies

package esae_pkg;

  localparam int unsigned MaxTagsDef       = 2;
  localparam int unsigned MaxFrameBytesDef = 2047;

  // frame layout, in bytes from the destination mac
  localparam int unsigned MacFirst   = 6;
  localparam int unsigned MacEnd     = 12;
  localparam int unsigned TypeStart  = 12;
  localparam int unsigned TagBytes   = 4;

  // sender address offsets from the first payload byte, and lengths
  localparam int unsigned Ipv4AddrOfs = 12;
  localparam int unsigned ArpAddrOfs  = 14;
  localparam int unsigned Ipv6AddrOfs = 8;
  localparam int unsigned Ipv4AddrLen = 4;
  localparam int unsigned Ipv6AddrLen = 16;

  localparam logic [15:0] LenMax       = 16'd1500;
  localparam logic [15:0] EtypeVlan    = 16'h8100;
  localparam logic [15:0] EtypeQinq    = 16'h88A8;
  localparam logic [15:0] EtypeVlanAlt = 16'h9100;
  localparam logic [15:0] EtypeIpv4    = 16'h0800;
  localparam logic [15:0] EtypeArp     = 16'h0806;
  localparam logic [15:0] EtypeIpv6    = 16'h86DD;

  localparam logic [31:0] V4MappedHi = 32'h0000FFFF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_ADDR,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    KIND_IPV4  = 3'd0,
    KIND_ARP   = 3'd1,
    KIND_IPV6  = 3'd2,
    KIND_LEN   = 3'd3,
    KIND_UNSUP = 3'd4,
    KIND_TRUNC = 3'd5
  } kind_e;

  typedef struct packed {
    logic [63:0] frame_time;
    kind_e       payload_kind;
    logic [63:0] ip_lower;
    logic [63:0] ip_upper;
    logic [47:0] source_mac;
  } result_t;

endpackage

[hw/rtl/ethernet_source_address_extractor_unit.sv]
// ethernet_source_address_extractor_unit: top level, byte stream in, one record per frame out
// depends on esae_pkg and esae_parser
//
// channel   dir  tdata                                       tuser         tlast
// s_axis    in   [7:0] data_byte, [71:8] capture_time        first_byte    last_byte
// m_axis    out  [47:0] source_mac, [111:48] ip_upper,       payload_kind  -
//                [175:112] ip_lower, [239:176] frame_time
//
// one byte per clock; the parse state updates in the cycle a byte transaction is taken
// a record appears on m_axis the cycle after the frame's last byte when the output
// register is free or draining, otherwise it waits in the skid entry
// output register plus one skid entry: bytes keep flowing while a record waits,
// s_axis stalls only when both hold a record
// rst_ni clears the valid flags and parser state; parsing resumes at the next first_byte

module ethernet_source_address_extractor_unit #(
  parameter int unsigned MAX_TAGS        = esae_pkg::MaxTagsDef,
  parameter int unsigned MAX_FRAME_BYTES = esae_pkg::MaxFrameBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [71:0]   s_axis_tdata,   // data_byte, capture_time
  input  logic          s_axis_tuser,   // first_byte
  input  logic          s_axis_tlast,   // last_byte
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [239:0]  m_axis_tdata,   // source_mac, ip_upper, ip_lower, frame_time
  output logic [2:0]    m_axis_tuser    // payload_kind
);

  logic              accept, pop;
  logic              res_valid;
  esae_pkg::result_t res;
  esae_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic              out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  esae_parser #(
    .MAX_TAGS        (MAX_TAGS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (s_axis_tdata[7:0]),
    .first_byte_i   (s_axis_tuser),
    .last_byte_i    (s_axis_tlast),
    .capture_time_i (s_axis_tdata[71:8]),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      // input is stalled here, so only drain
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || pop) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.frame_time, out_q.ip_lower, out_q.ip_upper, out_q.source_mac};
  assign m_axis_tuser  = out_q.payload_kind;

endmodule

[hw/rtl/esae_parser.sv]
// esae_parser: per-byte header parse state and result formation
// depends on esae_pkg

module esae_parser #(
  parameter int unsigned MAX_TAGS        = esae_pkg::MaxTagsDef,
  parameter int unsigned MAX_FRAME_BYTES = esae_pkg::MaxFrameBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              first_byte_i,
  input  logic              last_byte_i,
  input  logic [63:0]       capture_time_i,
  output logic              res_valid_o,
  output esae_pkg::result_t res_o
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned TAG_W = (MAX_TAGS > 0) ? $clog2(MAX_TAGS + 1) : 1;

  esae_pkg::phase_e phase_q, phase_d, phase_c, phase_n;
  esae_pkg::kind_e  kind_q, kind_d, kind_c;
  logic [POS_W-1:0] pos_q, pos_d, pos_c;
  logic [POS_W-1:0] afs_q, afs_d, afs_c;
  logic [TAG_W-1:0] tags_q, tags_d, tags_c;
  logic [7:0]       type_hi_q, type_hi_d, type_hi_c;
  logic [47:0]      mac_q, mac_d, mac_c;
  logic [127:0]     ip_q, ip_d, ip_c;
  logic [63:0]      time_q, time_d, time_c;

  logic [POS_W:0]   pos_x, afs_x, addr_end;
  logic [15:0]      type_word;
  logic             has_ip;

  always_comb begin
    // a first byte restarts the frame before the byte itself is parsed
    phase_c   = first_byte_i ? esae_pkg::PH_HEADER : phase_q;
    pos_c     = first_byte_i ? '0 : pos_q;
    afs_c     = first_byte_i ? POS_W'(esae_pkg::TypeStart) : afs_q;
    tags_c    = first_byte_i ? '0 : tags_q;
    type_hi_c = first_byte_i ? '0 : type_hi_q;
    mac_c     = first_byte_i ? '0 : mac_q;
    ip_c      = first_byte_i ? '0 : ip_q;
    kind_c    = first_byte_i ? esae_pkg::KIND_IPV4 : kind_q;
    time_c    = first_byte_i ? capture_time_i : time_q;

    phase_n   = phase_c;
    afs_d     = afs_c;
    tags_d    = tags_c;
    type_hi_d = type_hi_c;
    mac_d     = mac_c;
    ip_d      = ip_c;
    kind_d    = kind_c;
    time_d    = time_c;
    pos_d     = pos_c;

    pos_x     = {1'b0, pos_c};
    afs_x     = {1'b0, afs_c};
    type_word = {type_hi_c, data_byte_i};
    addr_end  = afs_x + ((kind_c == esae_pkg::KIND_IPV6) ?
                         (POS_W+1)'(esae_pkg::Ipv6AddrLen - 1) :
                         (POS_W+1)'(esae_pkg::Ipv4AddrLen - 1));

    if (phase_c != esae_pkg::PH_IDLE) begin
      if (pos_c >= POS_W'(esae_pkg::MacFirst) && pos_c < POS_W'(esae_pkg::MacEnd)) begin
        mac_d = {mac_c[39:0], data_byte_i};
      end

      unique case (phase_c)
        esae_pkg::PH_HEADER: begin
          if (pos_c == afs_c) begin
            type_hi_d = data_byte_i;
          end else if (pos_x == afs_x + 1'b1) begin
            priority if (type_word == esae_pkg::EtypeVlan || type_word == esae_pkg::EtypeQinq ||
                         type_word == esae_pkg::EtypeVlanAlt) begin
              if (tags_c < TAG_W'(MAX_TAGS)) begin
                tags_d = tags_c + 1'b1;
                afs_d  = afs_c + POS_W'(esae_pkg::TagBytes);
              end else begin
                kind_d  = esae_pkg::KIND_UNSUP;
                phase_n = esae_pkg::PH_DONE;
              end
            end else if (type_word <= esae_pkg::LenMax) begin
              kind_d  = esae_pkg::KIND_LEN;
              phase_n = esae_pkg::PH_DONE;
            end else if (type_word == esae_pkg::EtypeIpv4) begin
              kind_d  = esae_pkg::KIND_IPV4;
              afs_d   = pos_c + POS_W'(1 + esae_pkg::Ipv4AddrOfs);
              phase_n = esae_pkg::PH_ADDR;
            end else if (type_word == esae_pkg::EtypeArp) begin
              kind_d  = esae_pkg::KIND_ARP;
              afs_d   = pos_c + POS_W'(1 + esae_pkg::ArpAddrOfs);
              phase_n = esae_pkg::PH_ADDR;
            end else if (type_word == esae_pkg::EtypeIpv6) begin
              kind_d  = esae_pkg::KIND_IPV6;
              afs_d   = pos_c + POS_W'(1 + esae_pkg::Ipv6AddrOfs);
              phase_n = esae_pkg::PH_ADDR;
            end else begin
              kind_d  = esae_pkg::KIND_UNSUP;
              phase_n = esae_pkg::PH_DONE;
            end
          end
        end
        esae_pkg::PH_ADDR: begin
          if (pos_x >= afs_x && pos_x <= addr_end) begin
            ip_d = {ip_c[119:0], data_byte_i};
            if (pos_x == addr_end) begin
              if (kind_c != esae_pkg::KIND_IPV6) begin
                ip_d = {64'h0, esae_pkg::V4MappedHi, ip_d[31:0]};
              end
              phase_n = esae_pkg::PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase

      if (pos_c < POS_W'(MAX_FRAME_BYTES)) begin
        pos_d = pos_c + 1'b1;
      end
    end

    res_valid_o = accept_i && (phase_c != esae_pkg::PH_IDLE) && last_byte_i;
    phase_d     = res_valid_o ? esae_pkg::PH_IDLE : phase_n;

    has_ip = (phase_n == esae_pkg::PH_DONE) && (kind_d <= esae_pkg::KIND_IPV6);
    res_o.source_mac   = mac_d;
    res_o.frame_time   = time_d;
    res_o.ip_upper     = has_ip ? ip_d[127:64] : '0;
    res_o.ip_lower     = has_ip ? ip_d[63:0] : '0;
    res_o.payload_kind = (phase_n == esae_pkg::PH_DONE) ? kind_d : esae_pkg::KIND_TRUNC;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= esae_pkg::PH_IDLE;
      pos_q     <= '0;
      afs_q     <= '0;
      tags_q    <= '0;
      type_hi_q <= '0;
      kind_q    <= esae_pkg::KIND_IPV4;
      mac_q     <= '0;
      ip_q      <= '0;
      time_q    <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      afs_q     <= afs_d;
      tags_q    <= tags_d;
      type_hi_q <= type_hi_d;
      kind_q    <= kind_d;
      mac_q     <= mac_d;
      ip_q      <= ip_d;
      time_q    <= time_d;
    end
  end

endmodule
